// File: design/dcfd_pkg.sv
package dcfd_pkg;

	localparam int PosW = 5;

	localparam logic [7:0] PREAMBLE = 8'hEA;
	localparam logic [7:0] HAND_OPEN_CODE = 8'h01;
	localparam logic [7:0] HAND_CLOSE_CODE = 8'h02;
	localparam int CHUTE_EN_BIT = 6;
	localparam int LID_OPEN_BIT = 7;

	// frame positions
	localparam logic [PosW-1:0] POS_IDLE = 5'd0;
	localparam logic [PosW-1:0] POS_LSPD_LO = 5'd1;
	localparam logic [PosW-1:0] POS_LSPD_HI = 5'd2;
	localparam logic [PosW-1:0] POS_LDIR = 5'd3;
	localparam logic [PosW-1:0] POS_RSPD_LO = 5'd4;
	localparam logic [PosW-1:0] POS_RSPD_HI = 5'd5;
	localparam logic [PosW-1:0] POS_RDIR = 5'd6;
	localparam logic [PosW-1:0] POS_J0_LO = 5'd7;
	localparam logic [PosW-1:0] POS_J0_HI = 5'd8;
	localparam logic [PosW-1:0] POS_J1_LO = 5'd9;
	localparam logic [PosW-1:0] POS_J1_HI = 5'd10;
	localparam logic [PosW-1:0] POS_J2_LO = 5'd11;
	localparam logic [PosW-1:0] POS_J2_HI = 5'd12;
	localparam logic [PosW-1:0] POS_J3_LO = 5'd13;
	localparam logic [PosW-1:0] POS_J3_HI = 5'd14;
	localparam logic [PosW-1:0] POS_HAND = 5'd15;
	localparam logic [PosW-1:0] POS_CHUTE = 5'd16;

	// action codes
	localparam logic [3:0] ACT_NONE = 4'd0;
	localparam logic [3:0] ACT_LSPD = 4'd1;
	localparam logic [3:0] ACT_LDIR = 4'd2;
	localparam logic [3:0] ACT_RSPD = 4'd3;
	localparam logic [3:0] ACT_RDIR = 4'd4;
	localparam logic [3:0] ACT_JOINT = 4'd5;
	localparam logic [3:0] ACT_HAND = 4'd6;
	localparam logic [3:0] ACT_CHUTE = 4'd7;
	localparam logic [3:0] ACT_ERROR = 4'd8;

	// config register indexes and reset values
	localparam logic REG_LID_OPEN = 1'b0;
	localparam logic REG_LID_CLOSED = 1'b1;
	localparam logic [15:0] LID_OPEN_RST = 16'd1000;
	localparam logic [15:0] LID_CLOSED_RST = 16'd2000;

	localparam int TdataW = 48;

	typedef struct packed {
		logic [15:0] lid_compare;
		logic [3:0]  chute_close_mask;
		logic        chute_update;
		logic        hand_enable;
		logic        hand_close_drive;
		logic        hand_open_drive;
		logic        dir_level;
		logic [1:0]  joint_index;
		logic [15:0] value;
	} result_t;

	localparam int ResultW = $bits(result_t);

endpackage

// File: design/drive_command_frame_decoder.sv
// Each accepted input word passes one input register, one decode step and one output
// register to m_tdata/m_tuser. Throughput: 1 word per cycle while m_tready is high.
// Exactly one result word per input word.
// Reset (arst_n low, asynchronous): both stages empty, frame decoder waits for the
// preamble, held low byte 0, lid compares 1000 (open) and 2000 (closed).
module drive_command_frame_decoder import dcfd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,  // [7:0] rx_byte
	input  logic               s_tuser,  // [0] rx_error
	output logic               m_tvalid,
	input  logic               m_tready,
	// [15:0] value, [17:16] joint_index, [18] dir_level, [19] hand_open_drive,
	// [20] hand_close_drive, [21] hand_enable, [22] chute_update,
	// [26:23] chute_close_mask, [42:27] lid_compare, [47:43] zero
	output logic [TdataW-1:0]  m_tdata,
	output logic [3:0]         m_tuser,  // [3:0] action
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	logic        valid_s1;
	logic [7:0]  rx_byte_s1;
	logic        rx_error_s1;
	logic        advance;
	logic        out_valid_q;
	logic [3:0]  action_q;
	result_t     res_q;
	logic [3:0]  dec_action;
	result_t     dec_res;
	logic [15:0] lid_open_q;
	logic [15:0] lid_closed_q;

	dcfd_regs u_regs (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.lid_open_q   (lid_open_q),
		.lid_closed_q (lid_closed_q)
	);

	// s1 moves on whenever the output register is empty or being drained
	assign advance = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			rx_byte_s1 <= s_tdata;
			rx_error_s1 <= s_tuser;
		end
	end

	dcfd_decode u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.rx_byte    (rx_byte_s1),
		.rx_error   (rx_error_s1),
		.lid_open   (lid_open_q),
		.lid_closed (lid_closed_q),
		.action     (dec_action),
		.res        (dec_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			action_q <= dec_action;
			res_q <= dec_res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser = action_q;
	assign m_tdata = {{(TdataW - ResultW){1'b0}}, res_q};

endmodule

// File: design/dcfd_regs.sv
module dcfd_regs import dcfd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [15:0] lid_open_q,
	output logic [15:0] lid_closed_q
);

	logic wr_en;
	logic reg_sel;

	assign pready = 1'b1;
	assign wr_en = psel & penable & pwrite;
	assign reg_sel = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lid_open_q <= LID_OPEN_RST;
			lid_closed_q <= LID_CLOSED_RST;
		end else if (wr_en) begin
			if (reg_sel == REG_LID_OPEN) begin
				lid_open_q <= pwdata[15:0];
			end else begin
				lid_closed_q <= pwdata[15:0];
			end
		end
	end

	always_comb begin
		prdata = 32'd0;
		case (reg_sel)
			REG_LID_OPEN: prdata = {16'd0, lid_open_q};
			REG_LID_CLOSED: prdata = {16'd0, lid_closed_q};
			default: prdata = 32'd0;
		endcase
	end

endmodule

// File: design/dcfd_decode.sv
module dcfd_decode import dcfd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        advance,
	input  logic [7:0]  rx_byte,
	input  logic        rx_error,
	input  logic [15:0] lid_open,
	input  logic [15:0] lid_closed,
	output logic [3:0]  action,
	output result_t     res
);

	logic [PosW-1:0] pos_q;
	logic [PosW-1:0] pos_nxt;
	logic [7:0]      held_lo_q;
	logic            load_lo;
	logic [PosW-1:0] joint_off;

	assign joint_off = pos_q - POS_J0_HI;

	always_comb begin
		action = ACT_NONE;
		res = '0;
		pos_nxt = pos_q + 5'd1;
		load_lo = 1'b0;
		if (rx_error) begin
			action = ACT_ERROR;
			pos_nxt = pos_q;
		end else begin
			case (pos_q) inside
				POS_IDLE: begin
					pos_nxt = (rx_byte == PREAMBLE) ? POS_LSPD_LO : POS_IDLE;
				end
				POS_LSPD_LO, POS_RSPD_LO, POS_J0_LO, POS_J1_LO, POS_J2_LO,
				POS_J3_LO: begin
					load_lo = 1'b1;
				end
				POS_LSPD_HI: begin
					action = ACT_LSPD;
					res.value = {rx_byte, held_lo_q};
				end
				POS_LDIR: begin
					action = ACT_LDIR;
					res.dir_level = (rx_byte == 8'd0);
				end
				POS_RSPD_HI: begin
					action = ACT_RSPD;
					res.value = {rx_byte, held_lo_q};
				end
				POS_RDIR: begin
					action = ACT_RDIR;
					res.dir_level = rx_byte[0];
				end
				POS_J0_HI, POS_J1_HI, POS_J2_HI, POS_J3_HI: begin
					action = ACT_JOINT;
					res.value = {rx_byte, held_lo_q};
					res.joint_index = joint_off[2:1];
				end
				POS_HAND: begin
					action = ACT_HAND;
					res.hand_open_drive = (rx_byte == HAND_OPEN_CODE);
					res.hand_close_drive = (rx_byte == HAND_CLOSE_CODE);
					res.hand_enable = (rx_byte == HAND_OPEN_CODE) ||
						(rx_byte == HAND_CLOSE_CODE);
				end
				POS_CHUTE: begin
					action = ACT_CHUTE;
					res.chute_update = rx_byte[CHUTE_EN_BIT];
					res.chute_close_mask = rx_byte[CHUTE_EN_BIT] ? rx_byte[3:0] : 4'd0;
					res.lid_compare = rx_byte[LID_OPEN_BIT] ? lid_open : lid_closed;
					pos_nxt = POS_IDLE;
				end
				default: begin
					// past the end of a frame: resync
					pos_nxt = POS_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_IDLE;
			held_lo_q <= 8'd0;
		end else if (advance) begin
			pos_q <= pos_nxt;
			if (load_lo) begin
				held_lo_q <= rx_byte;
			end
		end
	end

endmodule

// File: design/dcfd_checker.sv
module dcfd_checker import dcfd_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              m_tvalid,
	input logic              m_tready,
	input logic [TdataW-1:0] m_tdata,
	input logic [3:0]        m_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed while stalled");

	a_action_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser <= ACT_ERROR)
		else $error("action code out of range");

	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !(m_tuser == ACT_LSPD || m_tuser == ACT_RSPD || m_tuser == ACT_JOINT)
		|-> m_tdata[15:0] == 16'd0)
		else $error("value set for an action without a word");

	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ACT_ERROR |-> m_tdata == '0)
		else $error("error word carries data");

	a_hand_lines: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[19] && m_tdata[20]) && (m_tdata[21] == (m_tdata[19] || m_tdata[20])))
		else $error("hand lines inconsistent");

endmodule

bind drive_command_frame_decoder dcfd_checker u_dcfd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// File: sim/tb_drive_command_frame_decoder.sv
module tb_drive_command_frame_decoder;
	import dcfd_pkg::*;

	typedef struct packed {
		logic [7:0] data;
		logic       err;
	} rx_word_t;

	typedef struct packed {
		logic [3:0] act;
		result_t    res;
	} decoded_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [7:0]        s_tdata = 8'h00;
	logic              s_tuser = 1'b0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [TdataW-1:0] m_tdata;
	logic [3:0]        m_tuser;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [2:0]        paddr = 3'd0;
	logic [31:0]       pwdata = 32'd0;
	logic [31:0]       prdata;
	logic              pready;

	drive_command_frame_decoder dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// decoder state as the testbench sees it
	logic [PosW-1:0] frame_pos = POS_IDLE;
	logic [7:0]      low_byte = 8'h00;
	logic [15:0]     lid_open_cfg = LID_OPEN_RST;
	logic [15:0]     lid_closed_cfg = LID_CLOSED_RST;

	rx_word_t rx_words_q[$];
	decoded_t decoded_q[$];

	bit in_taken = 1'b0;
	bit send_steady = 1'b0;
	bit recv_steady = 1'b0;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;
	int send_gap = 0;
	int recv_gap = 0;
	int hold_left = 0;
	int queued_words = 0;
	int words_in = 0;
	int results_out = 0;
	int frames_done = 0;
	int error_words = 0;
	int mismatches = 0;

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#(12 * 400000);
		$display("end of test: mismatches");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic decoded_t decode_word(input logic [7:0] b, input logic err);
		decoded_t        d;
		logic [PosW-1:0] nxt;
		logic [PosW-1:0] jdiff;
		d = '0;
		d.act = ACT_NONE;
		nxt = frame_pos + 5'd1;
		jdiff = frame_pos - POS_J0_HI;
		if (err) begin
			// state holds on a flagged byte
			d.act = ACT_ERROR;
			nxt = frame_pos;
		end else begin
			case (frame_pos)
				POS_IDLE: nxt = (b == PREAMBLE) ? POS_LSPD_LO : POS_IDLE;
				POS_LSPD_LO, POS_RSPD_LO, POS_J0_LO, POS_J1_LO, POS_J2_LO, POS_J3_LO:
					low_byte = b;
				POS_LSPD_HI: begin
					d.act = ACT_LSPD;
					d.res.value = {b, low_byte};
				end
				POS_LDIR: begin
					d.act = ACT_LDIR;
					d.res.dir_level = (b == 8'h00);
				end
				POS_RSPD_HI: begin
					d.act = ACT_RSPD;
					d.res.value = {b, low_byte};
				end
				POS_RDIR: begin
					d.act = ACT_RDIR;
					d.res.dir_level = b[0];
				end
				POS_J0_HI, POS_J1_HI, POS_J2_HI, POS_J3_HI: begin
					d.act = ACT_JOINT;
					d.res.value = {b, low_byte};
					d.res.joint_index = jdiff[2:1];
				end
				POS_HAND: begin
					d.act = ACT_HAND;
					d.res.hand_open_drive = (b == HAND_OPEN_CODE);
					d.res.hand_close_drive = (b == HAND_CLOSE_CODE);
					d.res.hand_enable = (b == HAND_OPEN_CODE) || (b == HAND_CLOSE_CODE);
				end
				POS_CHUTE: begin
					d.act = ACT_CHUTE;
					if (b[CHUTE_EN_BIT]) begin
						d.res.chute_update = 1'b1;
						d.res.chute_close_mask = b[3:0];
					end
					d.res.lid_compare = b[LID_OPEN_BIT] ? lid_open_cfg : lid_closed_cfg;
					nxt = POS_IDLE;
				end
				default: nxt = POS_IDLE;
			endcase
		end
		frame_pos = nxt;
		return d;
	endfunction

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] seen);
		if (seen !== want) begin
			$display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, seen);
			mismatches++;
		end
	endtask

	// input side: track accepted words and predict their results
	always @(posedge clk) begin : rx_track
		decoded_t d;
		in_taken = arst_n && s_tvalid && s_tready;
		if (in_taken) begin
			d = decode_word(s_tdata, s_tuser);
			if (d.act == ACT_CHUTE)
				frames_done++;
			if (d.act == ACT_ERROR)
				error_words++;
			decoded_q.push_back(d);
			words_in++;
		end
	end

	always @(negedge clk) begin : driver
		rx_word_t w;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || in_taken) begin
			if (send_gap > 0) begin
				send_gap--;
				s_tvalid <= 1'b0;
			end else if (rx_words_q.size() != 0) begin
				w = rx_words_q.pop_front();
				s_tdata <= w.data;
				s_tuser <= w.err;
				s_tvalid <= 1'b1;
				send_gap = send_steady ? 0 : pick_gap();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin : receiver
		if (hold_req && !hold_done) begin
			hold_left = 400;
			hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (recv_gap > 0) begin
			recv_gap--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if (!recv_steady && $urandom_range(0, 3) == 0)
				recv_gap = pick_gap();
		end
	end

	always @(posedge clk) begin : monitor
		decoded_t d;
		result_t  got;
		if (arst_n && m_tvalid && m_tready) begin
			results_out++;
			if (decoded_q.size() == 0) begin
				$display("%0t: unexpected result word: expected none, got tuser %0h tdata %0h",
					$time, m_tuser, m_tdata);
				mismatches++;
			end else begin
				d = decoded_q.pop_front();
				got = m_tdata[ResultW-1:0];
				check_field("action", 16'(d.act), 16'(m_tuser));
				check_field("value", d.res.value, got.value);
				check_field("joint_index", 16'(d.res.joint_index),
					16'(got.joint_index));
				check_field("dir_level", 16'(d.res.dir_level), 16'(got.dir_level));
				check_field("hand_open_drive", 16'(d.res.hand_open_drive),
					16'(got.hand_open_drive));
				check_field("hand_close_drive", 16'(d.res.hand_close_drive),
					16'(got.hand_close_drive));
				check_field("hand_enable", 16'(d.res.hand_enable),
					16'(got.hand_enable));
				check_field("chute_update", 16'(d.res.chute_update),
					16'(got.chute_update));
				check_field("chute_close_mask", 16'(d.res.chute_close_mask),
					16'(got.chute_close_mask));
				check_field("lid_compare", d.res.lid_compare, got.lid_compare);
				check_field("tdata pad", 16'h0000, 16'(m_tdata[TdataW-1:ResultW]));
			end
		end
	end

	task automatic push_word(input logic [7:0] b, input logic err);
		rx_word_t w;
		w.data = b;
		w.err = err;
		rx_words_q.push_back(w);
		queued_words++;
	endtask

	// one frame with random content; a broken one drops bytes and loses alignment
	task automatic queue_frame(input bit broken);
		logic [7:0] fb [17];
		int i;
		fb[0] = PREAMBLE;
		for (i = 1; i < 17; i++)
			fb[i] = 8'($urandom);
		if ($urandom_range(0, 3) == 0)
			fb[3] = 8'h00;
		if ($urandom_range(0, 7) == 0)
			{fb[2], fb[1]} = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
		case ($urandom_range(0, 3))
			0: fb[15] = HAND_OPEN_CODE;
			1: fb[15] = HAND_CLOSE_CODE;
			2: fb[15] = 8'h00;
			default: ;
		endcase
		for (i = 0; i < 17; i++) begin
			if ($urandom_range(0, 39) == 0)
				push_word(8'($urandom), 1'b1);
			if (!(broken && $urandom_range(0, 7) == 0))
				push_word(fb[i], 1'b0);
		end
	endtask

	task automatic write_reg(input logic idx, input logic [15:0] val);
		logic [15:0] upper;
		upper = 16'($urandom);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {upper, val};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == REG_LID_OPEN)
			lid_open_cfg = val;
		else
			lid_closed_cfg = val;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic drain();
		while (rx_words_q.size() != 0 || s_tvalid || decoded_q.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	initial begin : stim
		logic [8:0] opening [21];
		int phase;
		int target;
		int n;
		int r;
		// {err, byte}: junk and an error while idle, then a frame with an error inside
		opening = '{9'h100, 9'h0EB, 9'h06A, 9'h0EA, 9'h000, 9'h000, 9'h000, 9'h0FF,
			9'h0FF, 9'h1EA, 9'h0FF, 9'h034, 9'h012, 9'h0FF, 9'h0FF, 9'h001, 9'h080,
			9'h0FE, 9'h07F, 9'h003, 9'h0C5};
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (opening[i])
			push_word(opening[i][7:0], opening[i][8]);
		drain();

		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					write_reg(REG_LID_OPEN, 16'hFFFF);
					write_reg(REG_LID_CLOSED, 16'h0000);
				end
				1: begin
					write_reg(REG_LID_OPEN, 16'h0000);
					write_reg(REG_LID_CLOSED, 16'hFFFF);
				end
				default: begin
					write_reg(REG_LID_OPEN, 16'($urandom));
					write_reg(REG_LID_CLOSED, 16'($urandom));
				end
			endcase
			send_steady = (phase == 1) || (phase == 2);
			recv_steady = (phase == 1);
			// receiver sits still while the sender keeps the pipe full
			if (phase == 2)
				hold_req = 1'b1;
			target = queued_words + 285;
			while (queued_words < target) begin
				r = $urandom_range(0, 19);
				if (r < 16) begin
					queue_frame(1'b0);
				end else if (r < 18) begin
					queue_frame(1'b1);
				end else begin
					n = $urandom_range(1, 6);
					repeat (n) push_word(8'($urandom), $urandom_range(0, 3) == 0);
				end
			end
			drain();
		end

		$display("covered %0d words in, %0d results out, %0d complete frames, %0d error words",
			words_in, results_out, frames_done, error_words);
		$display("lid compares at reset, both extremes and random values; long output stall");
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// File: files.f
design/dcfd_pkg.sv
design/dcfd_regs.sv
design/dcfd_decode.sv
design/drive_command_frame_decoder.sv
design/dcfd_checker.sv
sim/tb_drive_command_frame_decoder.sv
